// ----- rtl/core/lfpd_pkg.sv -----
// shared constants, codes and stage types for the line follow pd drive core
`timescale 1ns / 1ps

package lfpd_pkg;

  // field widths
  localparam int ERR_W      = 10;
  localparam int DRIVE_W    = 11;
  localparam int GAIN_W     = 14;
  localparam int SPEED_W    = 10;
  localparam int LIMIT_W    = 8;
  localparam int FILT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // internal widths
  localparam int DIFF_W = ERR_W + 1;
  localparam int SUM_W  = 27;

  // control constants
  localparam int ERROR_MAGNITUDE  = 511;
  localparam int ALPHA_NUM        = 42;
  localparam int ALPHA_SHIFT      = 6;
  localparam int ALPHA_ONE        = 64;
  localparam int CORNER_THRESHOLD = 200;
  localparam int DRIVE_MIN        = 200;
  localparam int DRIVE_MAX        = 850;
  localparam int SEARCH_DUTY      = 200;
  localparam int GAIN_SCALE       = 100;
  localparam int CORR_MIN         = -32768;
  localparam int CORR_MAX         = 32767;

  // floor(x / 100) == (x * RECIP_MULT) >> RECIP_SHIFT for x below 2^31 / 52
  localparam int RECIP_SHIFT = 31;
  localparam longint RECIP_MULT =
    ((longint'(1) << RECIP_SHIFT) + GAIN_SCALE - 1) / GAIN_SCALE;

  // register reset values
  localparam int KP_STRAIGHT_RST = 3000;
  localparam int KD_STRAIGHT_RST = 1500;
  localparam int KP_CORNER_RST   = 5000;
  localparam int KD_CORNER_RST   = 3000;
  localparam int BASE_STR_RST    = 600;
  localparam int BASE_COR_RST    = 400;
  localparam int MAX_ACCEL_RST   = 50;
  localparam int LOST_LIMIT_RST  = 40;
  localparam int CURRENT_RST     = 600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_STRAIGHT = 3'd0,
    REG_KD_STRAIGHT = 3'd1,
    REG_KP_CORNER   = 3'd2,
    REG_KD_CORNER   = 3'd3,
    REG_BASE_STR    = 3'd4,
    REG_BASE_COR    = 3'd5,
    REG_MAX_ACCEL   = 3'd6,
    REG_LOST_LIMIT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_TRACK  = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_STOP   = 2'd2
  } mode_t;

  // filter stage to multiply stage
  typedef struct packed {
    mode_t                     mode;
    logic                      spin_left;
    logic signed [ERR_W-1:0]   smooth;
    logic signed [DIFF_W-1:0]  diff;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         kd;
    logic [SPEED_W-1:0]        base;
  } s1_t;

  // multiply stage to drive stage
  typedef struct packed {
    mode_t                     mode;
    logic                      spin_left;
    logic signed [SUM_W-1:0]   sum;
    logic [SPEED_W-1:0]        base;
  } s2_t;

endpackage

// ----- rtl/core/line_follow_pd_drive_core.sv -----
// line follow pd drive core: filter, pd correction, clamp and slew, search on line loss
// until the search limit, then stop; one request per cycle while out_stall is low;
// stage 1 filters into s1_r, stage 2 runs the two gain multiplies into s2_r, stage 3
// divides by 100 through a reciprocal multiply and slews into the out_ registers
// reset: synchronous active low; clears the pipeline, restores register defaults,
// zeroes filter and error state and sets both drive currents to 600
`timescale 1ns / 1ps

module line_follow_pd_drive_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_line_found,
  input  logic signed [lfpd_pkg::ERR_W-1:0]      in_position_error,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lfpd_pkg::DRIVE_W-1:0]    out_left_drive,
  output logic signed [lfpd_pkg::DRIVE_W-1:0]    out_right_drive,
  output logic                                   out_searching,
  output logic                                   out_stopped
);

  localparam int ERR_W   = lfpd_pkg::ERR_W;
  localparam int FILT_W  = lfpd_pkg::FILT_W;
  localparam int GAIN_W  = lfpd_pkg::GAIN_W;
  localparam int SPEED_W = lfpd_pkg::SPEED_W;
  localparam int LIMIT_W = lfpd_pkg::LIMIT_W;
  localparam int DIFF_W  = lfpd_pkg::DIFF_W;
  localparam int SUM_W   = lfpd_pkg::SUM_W;
  localparam int DRIVE_W = lfpd_pkg::DRIVE_W;

  localparam int FSUM_W = 24;
  localparam int MAG_W  = 25;
  localparam int PROD_W = 50;
  localparam int QUOT_W = PROD_W - lfpd_pkg::RECIP_SHIFT;
  localparam int CORR_W = QUOT_W + 1;
  localparam int CSAT_W = 17;
  localparam int TGT_W  = 18;
  localparam int SLEW_W = 12;

  localparam logic signed [ERR_W-1:0] ERR_LO = ERR_W'(-lfpd_pkg::ERROR_MAGNITUDE);
  localparam logic signed [FSUM_W-1:0] K_NEW =
    FSUM_W'(lfpd_pkg::ALPHA_NUM * lfpd_pkg::ALPHA_ONE);
  localparam logic signed [FSUM_W-1:0] K_OLD =
    FSUM_W'(lfpd_pkg::ALPHA_ONE - lfpd_pkg::ALPHA_NUM);
  localparam logic signed [CORR_W-1:0] C_LO = CORR_W'(lfpd_pkg::CORR_MIN);
  localparam logic signed [CORR_W-1:0] C_HI = CORR_W'(lfpd_pkg::CORR_MAX);
  localparam logic signed [TGT_W-1:0]  T_LO = TGT_W'(lfpd_pkg::DRIVE_MIN);
  localparam logic signed [TGT_W-1:0]  T_HI = TGT_W'(lfpd_pkg::DRIVE_MAX);
  localparam logic signed [DRIVE_W-1:0] SPIN = DRIVE_W'(lfpd_pkg::SEARCH_DUTY);

  // configuration registers
  logic [GAIN_W-1:0]  kp_str_r, kd_str_r, kp_cor_r, kd_cor_r;
  logic [SPEED_W-1:0] base_str_r, base_cor_r, max_accel_r;
  logic [LIMIT_W-1:0] lost_limit_r;

  // tick state
  logic signed [FILT_W-1:0] filt_r, filt_nxt;
  logic signed [ERR_W-1:0]  prev_r;
  logic [LIMIT_W-1:0]       lost_r;
  logic [SPEED_W-1:0]       left_cur_r, right_cur_r, left_cur_nxt, right_cur_nxt;

  // pipeline
  logic            v1_r, v2_r, out_valid_r;
  lfpd_pkg::s1_t   s1_r, s1_nxt;
  lfpd_pkg::s2_t   s2_r, s2_nxt;
  logic signed [DRIVE_W-1:0] left_r, right_r, left_nxt, right_nxt;
  logic            searching_r, stopped_r, searching_nxt, stopped_nxt;

  logic o_rdy, s2_rdy, s1_rdy, in_acc, s2_load, s3_load;

  assign o_rdy   = !out_valid_r || !out_stall;
  assign s2_rdy  = !v2_r || o_rdy;
  assign s1_rdy  = !v1_r || s2_rdy;
  assign in_acc  = in_valid && s1_rdy;
  assign s2_load = v1_r && s2_rdy;
  assign s3_load = v2_r && o_rdy;

  assign in_stall        = !s1_rdy;
  assign out_valid       = out_valid_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;
  assign out_searching   = searching_r;
  assign out_stopped     = stopped_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_str_r     <= GAIN_W'(lfpd_pkg::KP_STRAIGHT_RST);
      kd_str_r     <= GAIN_W'(lfpd_pkg::KD_STRAIGHT_RST);
      kp_cor_r     <= GAIN_W'(lfpd_pkg::KP_CORNER_RST);
      kd_cor_r     <= GAIN_W'(lfpd_pkg::KD_CORNER_RST);
      base_str_r   <= SPEED_W'(lfpd_pkg::BASE_STR_RST);
      base_cor_r   <= SPEED_W'(lfpd_pkg::BASE_COR_RST);
      max_accel_r  <= SPEED_W'(lfpd_pkg::MAX_ACCEL_RST);
      lost_limit_r <= LIMIT_W'(lfpd_pkg::LOST_LIMIT_RST);
    end else if (cfg_we) begin
      unique case (lfpd_pkg::cfg_reg_t'(cfg_index))
        lfpd_pkg::REG_KP_STRAIGHT: kp_str_r     <= cfg_wdata[GAIN_W-1:0];
        lfpd_pkg::REG_KD_STRAIGHT: kd_str_r     <= cfg_wdata[GAIN_W-1:0];
        lfpd_pkg::REG_KP_CORNER:   kp_cor_r     <= cfg_wdata[GAIN_W-1:0];
        lfpd_pkg::REG_KD_CORNER:   kd_cor_r     <= cfg_wdata[GAIN_W-1:0];
        lfpd_pkg::REG_BASE_STR:    base_str_r   <= cfg_wdata[SPEED_W-1:0];
        lfpd_pkg::REG_BASE_COR:    base_cor_r   <= cfg_wdata[SPEED_W-1:0];
        lfpd_pkg::REG_MAX_ACCEL:   max_accel_r  <= cfg_wdata[SPEED_W-1:0];
        lfpd_pkg::REG_LOST_LIMIT:  lost_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: saturate, low-pass filter, gain set and mode selection
  logic signed [ERR_W-1:0]  e_sat;
  logic [ERR_W-1:0]         e_abs;
  logic                     corner;
  logic signed [FSUM_W-1:0] fsum;

  always_comb begin
    e_sat    = (in_position_error < ERR_LO) ? ERR_LO : in_position_error;
    e_abs    = e_sat[ERR_W-1] ? ERR_W'(-e_sat) : ERR_W'(e_sat);
    corner   = e_abs > ERR_W'(lfpd_pkg::CORNER_THRESHOLD);
    fsum     = K_NEW * FSUM_W'(e_sat) + K_OLD * FSUM_W'(filt_r);
    filt_nxt = FILT_W'(fsum >>> lfpd_pkg::ALPHA_SHIFT);

    s1_nxt.spin_left = prev_r[ERR_W-1];
    s1_nxt.smooth    = ERR_W'(filt_nxt >>> lfpd_pkg::ALPHA_SHIFT);
    s1_nxt.diff      = DIFF_W'(e_sat) - DIFF_W'(prev_r);
    s1_nxt.kp        = corner ? kp_cor_r : kp_str_r;
    s1_nxt.kd        = corner ? kd_cor_r : kd_str_r;
    s1_nxt.base      = corner ? base_cor_r : base_str_r;
    if (in_line_found) begin
      s1_nxt.mode = lfpd_pkg::MODE_TRACK;
    end else if (lost_r < lost_limit_r) begin
      s1_nxt.mode = lfpd_pkg::MODE_SEARCH;
    end else begin
      s1_nxt.mode = lfpd_pkg::MODE_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
      prev_r <= '0;
      lost_r <= '0;
    end else if (in_acc) begin
      if (in_line_found) begin
        filt_r <= filt_nxt;
        prev_r <= e_sat;
        lost_r <= '0;
      end else if (lost_r < lost_limit_r) begin
        lost_r <= lost_r + LIMIT_W'(1);
      end
    end
  end

  // stage 2: proportional and derivative products
  always_comb begin
    s2_nxt.mode      = s1_r.mode;
    s2_nxt.spin_left = s1_r.spin_left;
    s2_nxt.base      = s1_r.base;
    s2_nxt.sum       = SUM_W'($signed({1'b0, s1_r.kp})) * SUM_W'(s1_r.smooth)
                     + SUM_W'($signed({1'b0, s1_r.kd})) * SUM_W'(s1_r.diff);
  end

  // stage 3: divide by gain scale, clamp, slew, select drive by mode
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic [QUOT_W-1:0]        quot;
  logic signed [CORR_W-1:0] corr, corr_sat;
  logic signed [TGT_W-1:0]  tl_raw, tr_raw, tl, tr;
  logic signed [SLEW_W-1:0] step, dl, dr;

  always_comb begin
    neg  = s2_r.sum[SUM_W-1];
    mag  = neg ? MAG_W'(-s2_r.sum) : MAG_W'(s2_r.sum);
    prod = PROD_W'(mag) * PROD_W'(lfpd_pkg::RECIP_MULT);
    quot = prod[PROD_W-1:lfpd_pkg::RECIP_SHIFT];
    corr = neg ? -CORR_W'(quot) : CORR_W'(quot);
    if (corr > C_HI) begin
      corr_sat = C_HI;
    end else if (corr < C_LO) begin
      corr_sat = C_LO;
    end else begin
      corr_sat = corr;
    end

    tl_raw = TGT_W'($signed({1'b0, s2_r.base})) + TGT_W'(CSAT_W'(corr_sat));
    tr_raw = TGT_W'($signed({1'b0, s2_r.base})) - TGT_W'(CSAT_W'(corr_sat));
    tl = (tl_raw > T_HI) ? T_HI : ((tl_raw < T_LO) ? T_LO : tl_raw);
    tr = (tr_raw > T_HI) ? T_HI : ((tr_raw < T_LO) ? T_LO : tr_raw);

    step = $signed({2'b00, max_accel_r});
    dl   = SLEW_W'(tl) - $signed({2'b00, left_cur_r});
    dr   = SLEW_W'(tr) - $signed({2'b00, right_cur_r});

    if (dl > step) begin
      left_cur_nxt = left_cur_r + max_accel_r;
    end else if (dl < -step) begin
      left_cur_nxt = left_cur_r - max_accel_r;
    end else begin
      left_cur_nxt = SPEED_W'(tl);
    end
    if (dr > step) begin
      right_cur_nxt = right_cur_r + max_accel_r;
    end else if (dr < -step) begin
      right_cur_nxt = right_cur_r - max_accel_r;
    end else begin
      right_cur_nxt = SPEED_W'(tr);
    end

    case (s2_r.mode)
      lfpd_pkg::MODE_TRACK: begin
        left_nxt      = $signed({1'b0, left_cur_nxt});
        right_nxt     = $signed({1'b0, right_cur_nxt});
        searching_nxt = 1'b0;
        stopped_nxt   = 1'b0;
      end
      lfpd_pkg::MODE_SEARCH: begin
        // spin toward the side of the last error
        left_nxt      = s2_r.spin_left ? -SPIN : SPIN;
        right_nxt     = s2_r.spin_left ? SPIN : -SPIN;
        searching_nxt = 1'b1;
        stopped_nxt   = 1'b0;
      end
      default: begin
        left_nxt      = '0;
        right_nxt     = '0;
        searching_nxt = 1'b0;
        stopped_nxt   = 1'b1;
      end
    endcase
  end

  // valids and drive currents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      left_cur_r  <= SPEED_W'(lfpd_pkg::CURRENT_RST);
      right_cur_r <= SPEED_W'(lfpd_pkg::CURRENT_RST);
    end else begin
      if (s1_rdy) begin
        v1_r <= in_valid;
      end
      if (s2_rdy) begin
        v2_r <= v1_r;
      end
      if (o_rdy) begin
        out_valid_r <= v2_r;
      end
      if (s3_load && s2_r.mode == lfpd_pkg::MODE_TRACK) begin
        left_cur_r  <= left_cur_nxt;
        right_cur_r <= right_cur_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s2_load) begin
      s2_r <= s2_nxt;
    end
    if (s3_load) begin
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      searching_r <= searching_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

endmodule

// ----- rtl/core/lfpd_checker.sv -----
// port-level checks for the line follow pd drive core, bound into the core module
`timescale 1ns / 1ps

module lfpd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic signed [lfpd_pkg::DRIVE_W-1:0] out_left_drive,
  input logic signed [lfpd_pkg::DRIVE_W-1:0] out_right_drive,
  input logic                                out_searching,
  input logic                                out_stopped
);

  localparam logic signed [lfpd_pkg::DRIVE_W-1:0] SPIN =
    lfpd_pkg::DRIVE_W'(lfpd_pkg::SEARCH_DUTY);
  localparam logic signed [lfpd_pkg::DRIVE_W-1:0] D_LO =
    lfpd_pkg::DRIVE_W'(lfpd_pkg::DRIVE_MIN);
  localparam logic signed [lfpd_pkg::DRIVE_W-1:0] D_HI =
    lfpd_pkg::DRIVE_W'(lfpd_pkg::DRIVE_MAX);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_searching && out_stopped))
    else $error("searching and stopped both set");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stopped) |-> (out_left_drive == '0 && out_right_drive == '0))
    else $error("stopped with nonzero drive");

  // search spins the two sides in opposite directions at search duty
  a_search_spin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_searching) |->
      ((out_left_drive == SPIN && out_right_drive == -SPIN) ||
       (out_left_drive == -SPIN && out_right_drive == SPIN)))
    else $error("bad search drive");

  // tracking drive is a slewed current that only moves toward a clamped target,
  // so it never leaves the clamp window
  a_track_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_searching && !out_stopped) |->
      (out_left_drive >= D_LO && out_left_drive <= D_HI &&
       out_right_drive >= D_LO && out_right_drive <= D_HI))
    else $error("tracking drive out of range");

endmodule

bind line_follow_pd_drive_core lfpd_checker u_lfpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_left_drive  (out_left_drive),
  .out_right_drive (out_right_drive),
  .out_searching   (out_searching),
  .out_stopped     (out_stopped)
);

// ----- dv/lfpd_drive_checker.sv -----
// checker for the line follow pd drive core: tracks config writes, predicts each tick, compares
`timescale 1ns / 1ps

module lfpd_drive_checker
  import lfpd_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_line_found,
  input  logic signed [ERR_W-1:0]           in_position_error,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [DRIVE_W-1:0]         out_left_drive,
  input  logic signed [DRIVE_W-1:0]         out_right_drive,
  input  logic                              out_searching,
  input  logic                              out_stopped,
  output int                                pending,
  output int                                fail_cnt
);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic                      searching;
    logic                      stopped;
  } drive_t;

  // shadow registers
  logic [GAIN_W-1:0]  kp_str, kd_str, kp_cor, kd_cor;
  logic [SPEED_W-1:0] base_str, base_cor, accel;
  logic [LIMIT_W-1:0] lost_lim;

  // shadow controller state
  logic signed [FILT_W-1:0] filt_q;
  logic signed [ERR_W-1:0]  prev_q;
  logic [SPEED_W-1:0]       left_q, right_q;
  logic [LIMIT_W-1:0]       lost_q;

  drive_t drive_q[$];

  function automatic int clip(input int v, input int lo, input int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic int ramp(input int target, input int cur, input int step);
    if (target - cur > step) return cur + step;
    if (target - cur < -step) return cur - step;
    return target;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic predict_tick(input logic found, input logic signed [ERR_W-1:0] raw,
                              output drive_t res);
    int   e, mag, kp, kd, base, step, filt, sum, smooth, corr, tl, tr;
    logic corner;
    res = '0;
    if (found) begin
      e = raw;
      // -512 is outside the error range and saturates
      if (e < -ERROR_MAGNITUDE) e = -ERROR_MAGNITUDE;
      if (e > ERROR_MAGNITUDE) e = ERROR_MAGNITUDE;
      mag = (e < 0) ? -e : e;
      corner = mag > CORNER_THRESHOLD;
      kp = corner ? kp_cor : kp_str;
      kd = corner ? kd_cor : kd_str;
      base = corner ? base_cor : base_str;
      step = accel;
      filt = filt_q;
      sum = ALPHA_NUM * (e * ALPHA_ONE) + (ALPHA_ONE - ALPHA_NUM) * filt;
      filt = sum >>> ALPHA_SHIFT;
      smooth = filt >>> ALPHA_SHIFT;
      sum = kp * smooth + kd * (e - int'(prev_q));
      // int division truncates toward zero
      corr = clip(sum / GAIN_SCALE, CORR_MIN, CORR_MAX);
      tl = clip(base + corr, DRIVE_MIN, DRIVE_MAX);
      tr = clip(base - corr, DRIVE_MIN, DRIVE_MAX);
      tl = ramp(tl, int'(left_q), step);
      tr = ramp(tr, int'(right_q), step);
      filt_q = filt[FILT_W-1:0];
      prev_q = e[ERR_W-1:0];
      left_q = tl[SPEED_W-1:0];
      right_q = tr[SPEED_W-1:0];
      lost_q = '0;
      res.left = tl[DRIVE_W-1:0];
      res.right = tr[DRIVE_W-1:0];
    end else if (lost_q < lost_lim) begin
      // spin toward the side the line was last seen on
      if (prev_q < 0) begin
        res.left = DRIVE_W'(-SEARCH_DUTY);
        res.right = DRIVE_W'(SEARCH_DUTY);
      end else begin
        res.left = DRIVE_W'(SEARCH_DUTY);
        res.right = DRIVE_W'(-SEARCH_DUTY);
      end
      res.searching = 1'b1;
      lost_q = lost_q + 1'b1;
    end else begin
      res.stopped = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    drive_t want, got;
    if (!rst_n) begin
      kp_str = GAIN_W'(KP_STRAIGHT_RST);
      kd_str = GAIN_W'(KD_STRAIGHT_RST);
      kp_cor = GAIN_W'(KP_CORNER_RST);
      kd_cor = GAIN_W'(KD_CORNER_RST);
      base_str = SPEED_W'(BASE_STR_RST);
      base_cor = SPEED_W'(BASE_COR_RST);
      accel = SPEED_W'(MAX_ACCEL_RST);
      lost_lim = LIMIT_W'(LOST_LIMIT_RST);
      filt_q = '0;
      prev_q = '0;
      left_q = SPEED_W'(CURRENT_RST);
      right_q = SPEED_W'(CURRENT_RST);
      lost_q = '0;
      drive_q.delete();
      pending = 0;
      fail_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.left = out_left_drive;
        got.right = out_right_drive;
        got.searching = out_searching;
        got.stopped = out_stopped;
        if (drive_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0d %0d %0b %0b", $time,
                   got.left, got.right, got.searching, got.stopped);
          fail_cnt++;
        end else begin
          want = drive_q.pop_front();
          check_field("left_drive", want.left, got.left);
          check_field("right_drive", want.right, got.right);
          check_field("searching", want.searching, got.searching);
          check_field("stopped", want.stopped, got.stopped);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KP_STRAIGHT: kp_str = cfg_wdata[GAIN_W-1:0];
          REG_KD_STRAIGHT: kd_str = cfg_wdata[GAIN_W-1:0];
          REG_KP_CORNER:   kp_cor = cfg_wdata[GAIN_W-1:0];
          REG_KD_CORNER:   kd_cor = cfg_wdata[GAIN_W-1:0];
          REG_BASE_STR:    base_str = cfg_wdata[SPEED_W-1:0];
          REG_BASE_COR:    base_cor = cfg_wdata[SPEED_W-1:0];
          REG_MAX_ACCEL:   accel = cfg_wdata[SPEED_W-1:0];
          REG_LOST_LIMIT:  lost_lim = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_tick(in_line_found, in_position_error, want);
        drive_q.push_back(want);
      end
      pending = drive_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// testbench top for the line follow pd drive core: reset, config phases, tick stimulus, verdict
`timescale 1ns / 1ps

module tb;
  import lfpd_pkg::*;

  localparam int PIPE_DEPTH  = 3;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_s;
    logic [GAIN_W-1:0]  kd_s;
    logic [GAIN_W-1:0]  kp_c;
    logic [GAIN_W-1:0]  kd_c;
    logic [SPEED_W-1:0] base_s;
    logic [SPEED_W-1:0] base_c;
    logic [SPEED_W-1:0] accel;
    logic [LIMIT_W-1:0] lost;
  } tune_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_line_found = 1'b0;
  logic signed [ERR_W-1:0]     in_position_error = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]   out_left_drive;
  logic signed [DRIVE_W-1:0]   out_right_drive;
  logic                        out_searching;
  logic                        out_stopped;

  int   pending;
  int   fail_cnt;
  int   cycle_cnt = 0;
  logic gaps_on = 1'b1;
  int   lost_now = LOST_LIMIT_RST;

  line_follow_pd_drive_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_line_found     (in_line_found),
    .in_position_error (in_position_error),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_searching     (out_searching),
    .out_stopped       (out_stopped)
  );

  lfpd_drive_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_line_found     (in_line_found),
    .in_position_error (in_position_error),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_searching     (out_searching),
    .out_stopped       (out_stopped),
    .pending           (pending),
    .fail_cnt          (fail_cnt)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 32);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_tune(input tune_t t);
    put_reg(REG_KP_STRAIGHT, t.kp_s);
    put_reg(REG_KD_STRAIGHT, t.kd_s);
    put_reg(REG_KP_CORNER, t.kp_c);
    put_reg(REG_KD_CORNER, t.kd_c);
    put_reg(REG_BASE_STR, t.base_s);
    put_reg(REG_BASE_COR, t.base_c);
    put_reg(REG_MAX_ACCEL, t.accel);
    put_reg(REG_LOST_LIMIT, t.lost);
    cfg_we <= 1'b0;
    lost_now = t.lost;
    @(posedge clk);
  endtask

  // one tick request; valid stays up between back-to-back requests
  task automatic send_tick(input logic found, input int err_val);
    logic stalled;
    while (gaps_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_found <= found;
    in_position_error <= err_val[ERR_W-1:0];
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // drop valid and wait until every tick has come back
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic rand_tune(output tune_t t);
    t.kp_s = GAIN_W'($urandom_range(0, 10000));
    t.kd_s = GAIN_W'($urandom_range(0, 10000));
    t.kp_c = GAIN_W'($urandom_range(0, 10000));
    t.kd_c = GAIN_W'($urandom_range(0, 10000));
    t.base_s = SPEED_W'($urandom_range(0, 1000));
    t.base_c = SPEED_W'($urandom_range(0, 1000));
    t.accel = SPEED_W'($urandom_range(1, 1000));
    t.lost = LIMIT_W'($urandom_range(0, 255));
  endtask

  // mostly tracking runs with a wandering error, broken by line-loss bursts and jumps
  task automatic drive_course(input int n);
    int sent, walk, burst;
    sent = 0;
    walk = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 15) begin
        burst = ($urandom_range(7) == 0) ? lost_now + 2 : $urandom_range(1, 8);
        repeat (burst) begin
          send_tick(1'b0, $urandom);
          sent++;
        end
      end else begin
        repeat ($urandom_range(5, 40)) begin
          if ($urandom_range(99) < 10) walk = $urandom_range(0, 1023) - 512;
          else walk = walk + $urandom_range(0, 80) - 40;
          if (walk > 511) walk = 511;
          if (walk < -512) walk = -512;
          send_tick(1'b1, walk);
          sent++;
        end
      end
    end
  endtask

  initial begin
    tune_t t;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // high gains, one base at 1000 and one at zero, short search
    t.kp_s = GAIN_W'(10000);
    t.kd_s = GAIN_W'(10000);
    t.kp_c = GAIN_W'(16383);
    t.kd_c = GAIN_W'(16383);
    t.base_s = SPEED_W'(1000);
    t.base_c = '0;
    t.accel = SPEED_W'(1000);
    t.lost = LIMIT_W'(3);
    load_tune(t);
    send_tick(1'b1, 0);
    send_tick(1'b1, 511);
    send_tick(1'b1, -512);
    send_tick(1'b1, -511);
    send_tick(1'b1, 200);
    send_tick(1'b1, 201);
    send_tick(1'b1, -200);
    send_tick(1'b1, -201);
    send_tick(1'b1, 511);
    // search spins right, then times out
    repeat (5) send_tick(1'b0, $urandom);
    send_tick(1'b1, -300);
    send_tick(1'b0, -1);
    send_tick(1'b1, 0);
    drain();

    // zero gains, zero slew step, zero search time
    t.kp_s = '0;
    t.kd_s = '0;
    t.kp_c = '0;
    t.kd_c = '0;
    t.base_s = '0;
    t.base_c = SPEED_W'(1023);
    t.accel = '0;
    t.lost = '0;
    load_tune(t);
    send_tick(1'b1, 300);
    send_tick(1'b1, -300);
    send_tick(1'b0, 511);
    send_tick(1'b1, 0);
    drain();

    rand_tune(t);
    load_tune(t);
    drive_course(150);
    drain();

    // upper extremes with no idling on either side
    gaps_on <= 1'b0;
    rand_tune(t);
    t.base_s = SPEED_W'(1023);
    t.accel = SPEED_W'(1023);
    t.lost = LIMIT_W'(255);
    load_tune(t);
    drive_course(150);
    drain();
    gaps_on <= 1'b1;

    rand_tune(t);
    t.accel = SPEED_W'(1);
    t.lost = LIMIT_W'($urandom_range(0, 6));
    load_tune(t);
    drive_course(150);
    drain();

    rand_tune(t);
    load_tune(t);
    drive_course(150);
    drain();

    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lfpd_pkg.sv
rtl/core/line_follow_pd_drive_core.sv
rtl/core/lfpd_checker.sv
dv/lfpd_drive_checker.sv
dv/tb.sv
